// ===== hdl/rcm_pkg.sv =====
`default_nettype none

package rcm_pkg;

    // Image size limit and histogram geometry
    localparam int unsigned MaxPixels = 4096;
    localparam int unsigned NumBins   = 256;
    localparam int unsigned BinW      = 8;
    localparam int unsigned TotalW    = 13;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_WRITE,
        ST_SWEEP,
        ST_DRAIN,
        ST_HOLD
    } t_state;

    // Controls from the sequencer to each histogram memory
    typedef struct packed {
        logic            pix_ld;   // capture the pixel byte of an accepted request
        logic            sweep;    // address from the sweep counter
        logic            wr_inc;   // write back bin + 1
        logic            wr_zero;  // write zero to the swept bin
        logic            acc_clr;  // clear running sum and median
        logic            acc_en;   // read data of a search sweep is valid
        logic [BinW-1:0] addr;     // sweep address
        logic [BinW-1:0] addr_d;   // sweep address of the data now on the read port
    } t_hist_ctl;

endpackage

`default_nettype wire

// ===== hdl/rcm_hist.sv =====
`default_nettype none

module rcm_hist #(
    parameter int unsigned CNT_W = 13
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire rcm_pkg::t_hist_ctl            i_ctl,
    input  wire logic [rcm_pkg::BinW-1:0]      i_pix,
    input  wire logic [CNT_W-1:0]              i_rank,
    output logic      [rcm_pkg::BinW-1:0]      o_median
);

    logic [CNT_W-1:0]         mem [rcm_pkg::NumBins];
    logic [CNT_W-1:0]         r_rd;
    logic [rcm_pkg::BinW-1:0] r_pix;
    logic [rcm_pkg::BinW-1:0] addr;
    logic [CNT_W-1:0]         wdata;
    logic                     we;

    logic [CNT_W-1:0]         r_acc;
    logic [CNT_W-1:0]         n_acc;
    logic                     r_found;
    logic [rcm_pkg::BinW-1:0] r_med;

    // Pixel byte held for the read and write-back of its bin
    always_ff @(posedge i_clk) begin
        if (i_ctl.pix_ld) begin
            r_pix <= i_pix;
        end
    end

    // Address and write data selection
    always_comb begin
        addr  = i_ctl.sweep ? i_ctl.addr : (i_ctl.pix_ld ? i_pix : r_pix);
        we    = i_ctl.wr_inc | i_ctl.wr_zero;
        wdata = i_ctl.wr_zero ? '0 : r_rd + CNT_W'(1);
    end

    // Bin memory, registered read, read-before-write
    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        r_rd <= mem[addr];
    end

    // Running sum over the sweep; first bin whose sum passes the rank
    assign n_acc = r_acc + r_rd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.acc_clr) begin
            r_acc   <= '0;
            r_found <= 1'b0;
            r_med   <= '0;
        end else if (i_ctl.acc_en) begin
            r_acc <= n_acc;
            if (!r_found && (n_acc > i_rank)) begin
                r_found <= 1'b1;
                r_med   <= i_ctl.addr_d;
            end
        end
    end

    assign o_median = r_med;

endmodule

`default_nettype wire

// ===== hdl/rcm_ctrl.sv =====
`default_nettype none

module rcm_ctrl #(
    parameter int unsigned MAX_PIXELS = rcm_pkg::MaxPixels,
    parameter int unsigned CNT_W      = 13
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    input  wire logic               i_last_pixel,
    output logic                    o_ready,
    input  wire logic               i_out_busy,
    output rcm_pkg::t_hist_ctl      o_ctl,
    output logic [CNT_W-1:0]        o_rank,
    output logic                    o_load,
    output logic [CNT_W-1:0]        o_count,
    output logic                    o_overflow
);

    localparam logic [CNT_W-1:0]         MaxCnt  = CNT_W'(MAX_PIXELS);
    localparam logic [rcm_pkg::BinW-1:0] LastBin = rcm_pkg::BinW'(rcm_pkg::NumBins - 1);

    rcm_pkg::t_state          r_state;
    rcm_pkg::t_state          n_state;
    logic [rcm_pkg::BinW-1:0] r_addr;
    logic [rcm_pkg::BinW-1:0] r_addr_d;
    logic                     r_acc_en;
    logic [CNT_W-1:0]         r_count;
    logic                     r_ovf;
    logic                     r_last;
    logic                     accept;
    logic                     counted;

    assign accept  = (r_state == rcm_pkg::ST_IDLE) && i_valid;
    assign counted = r_count < MaxCnt;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            rcm_pkg::ST_CLEAR: begin
                if (r_addr == LastBin) n_state = rcm_pkg::ST_IDLE;
            end
            rcm_pkg::ST_IDLE: begin
                if (i_valid) begin
                    if (counted)           n_state = rcm_pkg::ST_READ;
                    else if (i_last_pixel) n_state = rcm_pkg::ST_SWEEP;
                end
            end
            rcm_pkg::ST_READ:  n_state = rcm_pkg::ST_WRITE;
            rcm_pkg::ST_WRITE: n_state = r_last ? rcm_pkg::ST_SWEEP : rcm_pkg::ST_IDLE;
            rcm_pkg::ST_SWEEP: begin
                if (r_addr == LastBin) n_state = rcm_pkg::ST_DRAIN;
            end
            rcm_pkg::ST_DRAIN: n_state = rcm_pkg::ST_HOLD;
            rcm_pkg::ST_HOLD: begin
                if (!i_out_busy) n_state = rcm_pkg::ST_IDLE;
            end
            default: n_state = rcm_pkg::ST_CLEAR;
        endcase
    end

    // Outputs
    always_comb begin
        o_ready         = (r_state == rcm_pkg::ST_IDLE);
        o_ctl.pix_ld    = accept;
        o_ctl.sweep     = (r_state == rcm_pkg::ST_SWEEP) || (r_state == rcm_pkg::ST_CLEAR);
        o_ctl.wr_zero   = o_ctl.sweep;
        o_ctl.wr_inc    = (r_state == rcm_pkg::ST_WRITE);
        o_ctl.acc_clr   = (r_state == rcm_pkg::ST_IDLE);
        o_ctl.acc_en    = r_acc_en;
        o_ctl.addr      = r_addr;
        o_ctl.addr_d    = r_addr_d;
        o_load          = (r_state == rcm_pkg::ST_HOLD) && !i_out_busy;
        o_rank          = r_count >> 1;
        o_count         = r_count;
        o_overflow      = r_ovf;
    end

    // State, sweep counter and image bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= rcm_pkg::ST_CLEAR;
            r_addr   <= '0;
            r_addr_d <= '0;
            r_acc_en <= 1'b0;
            r_count  <= '0;
            r_ovf    <= 1'b0;
            r_last   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_addr_d <= r_addr;
            r_acc_en <= (r_state == rcm_pkg::ST_SWEEP);
            if (o_ctl.sweep) r_addr <= r_addr + rcm_pkg::BinW'(1);
            else             r_addr <= '0;
            if (accept) begin
                r_last <= i_last_pixel;
                if (counted) r_count <= r_count + CNT_W'(1);
                else         r_ovf   <= 1'b1;
            end else if (o_load) begin
                r_count <= '0;
                r_ovf   <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

// ===== hdl/rgb_channel_median.sv =====
// Channel   Direction  Handshake          Payload
// pixel     in         i_valid / o_ready  i_blue, i_green, i_red, i_last_pixel
// result    out        o_valid / i_ready  o_median_blue/green/red, o_pixel_total, o_overflow
//
// A counted pixel goes through accept with the bin read issued, a second bin read,
// then write-back of bin + 1.
// A dropped pixel (count at MAX_PIXELS) is accepted but no bin is written.
// A last pixel adds a sweep over all bins of the bin memories (rank search and clear in
// one pass), a drain state and a hold state that loads the result register.
// After reset a clearing pass over all 256 bins runs before the first pixel is taken.
// A result waits in its output register while the next image streams in; the block
// stalls only if a second result is ready before the first one is taken.
`default_nettype none

module rgb_channel_median #(
    parameter int unsigned MAX_PIXELS = rcm_pkg::MaxPixels
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    output logic                                 o_ready,
    input  wire logic [rcm_pkg::BinW-1:0]        i_blue,
    input  wire logic [rcm_pkg::BinW-1:0]        i_green,
    input  wire logic [rcm_pkg::BinW-1:0]        i_red,
    input  wire logic                            i_last_pixel,
    output logic                                 o_valid,
    input  wire logic                            i_ready,
    output logic      [rcm_pkg::BinW-1:0]        o_median_blue,
    output logic      [rcm_pkg::BinW-1:0]        o_median_green,
    output logic      [rcm_pkg::BinW-1:0]        o_median_red,
    output logic      [rcm_pkg::TotalW-1:0]      o_pixel_total,
    output logic                                 o_overflow
);

    localparam int unsigned CntW = $clog2(MAX_PIXELS + 1);

    rcm_pkg::t_hist_ctl       ctl;
    logic [CntW-1:0]          rank;
    logic [CntW-1:0]          count;
    logic                     ovf;
    logic                     load;
    logic                     out_busy;
    logic [rcm_pkg::BinW-1:0] med_b;
    logic [rcm_pkg::BinW-1:0] med_g;
    logic [rcm_pkg::BinW-1:0] med_r;

    logic                       r_out_valid;
    logic [rcm_pkg::BinW-1:0]   r_med_b;
    logic [rcm_pkg::BinW-1:0]   r_med_g;
    logic [rcm_pkg::BinW-1:0]   r_med_r;
    logic [rcm_pkg::TotalW-1:0] r_total;
    logic                       r_ovf;

    assign out_busy = r_out_valid && !i_ready;

    // Sequencer
    rcm_ctrl #(
        .MAX_PIXELS (MAX_PIXELS),
        .CNT_W      (CntW)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_last_pixel (i_last_pixel),
        .o_ready      (o_ready),
        .i_out_busy   (out_busy),
        .o_ctl        (ctl),
        .o_rank       (rank),
        .o_load       (load),
        .o_count      (count),
        .o_overflow   (ovf)
    );

    // One bin memory per channel
    rcm_hist #(.CNT_W(CntW)) u_hist_blue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (ctl),
        .i_pix    (i_blue),
        .i_rank   (rank),
        .o_median (med_b)
    );

    rcm_hist #(.CNT_W(CntW)) u_hist_green (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (ctl),
        .i_pix    (i_green),
        .i_rank   (rank),
        .o_median (med_g)
    );

    rcm_hist #(.CNT_W(CntW)) u_hist_red (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (ctl),
        .i_pix    (i_red),
        .i_rank   (rank),
        .o_median (med_r)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_med_b <= med_b;
            r_med_g <= med_g;
            r_med_r <= med_r;
            r_total <= rcm_pkg::TotalW'(count);
            r_ovf   <= ovf;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_median_blue  = r_med_b;
    assign o_median_green = r_med_g;
    assign o_median_red   = r_med_r;
    assign o_pixel_total  = r_total;
    assign o_overflow     = r_ovf;

endmodule

`default_nettype wire

// ===== bench/median_checker.sv =====
`timescale 1ns / 100ps

module median_checker (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    input  wire logic                       i_o_ready,
    input  wire logic [rcm_pkg::BinW-1:0]   i_blue,
    input  wire logic [rcm_pkg::BinW-1:0]   i_green,
    input  wire logic [rcm_pkg::BinW-1:0]   i_red,
    input  wire logic                       i_last_pixel,
    input  wire logic                       i_o_valid,
    input  wire logic                       i_ready,
    input  wire logic [rcm_pkg::BinW-1:0]   i_median_blue,
    input  wire logic [rcm_pkg::BinW-1:0]   i_median_green,
    input  wire logic [rcm_pkg::BinW-1:0]   i_median_red,
    input  wire logic [rcm_pkg::TotalW-1:0] i_pixel_total,
    input  wire logic                       i_overflow,
    output int                              o_fail_count,
    output int                              o_pending
);

    localparam int ChBlue  = 0;
    localparam int ChGreen = 1;
    localparam int ChRed   = 2;

    typedef struct packed {
        logic [rcm_pkg::BinW-1:0]   blue;
        logic [rcm_pkg::BinW-1:0]   green;
        logic [rcm_pkg::BinW-1:0]   red;
        logic [rcm_pkg::TotalW-1:0] total;
        logic                       overflow;
    } t_median_result;

    // Model of the image statistics
    int unsigned    bin_count [3][rcm_pkg::NumBins];
    int unsigned    pixels_counted;
    bit             pixels_dropped;
    t_median_result expected_medians [$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    task automatic clear_image();
        for (int c = 0; c < 3; c++)
            for (int v = 0; v < rcm_pkg::NumBins; v++)
                bin_count[c][v] = 0;
        pixels_counted = 0;
        pixels_dropped = 0;
    endtask

    // Smallest bin value whose cumulative count exceeds the rank; zero if none does
    function automatic logic [rcm_pkg::BinW-1:0] rank_value(input int ch,
                                                            input int unsigned rank);
        int unsigned              running;
        logic [rcm_pkg::BinW-1:0] found;
        bit                       hit;
        running = 0;
        found   = '0;
        hit     = 0;
        for (int v = 0; v < rcm_pkg::NumBins; v++) begin
            running += bin_count[ch][v];
            if (!hit && running > rank) begin
                found = v[rcm_pkg::BinW-1:0];
                hit   = 1;
            end
        end
        return found;
    endfunction

    // Add one pixel request; on the last pixel queue the medians of the image
    task automatic count_pixel(input logic [rcm_pkg::BinW-1:0] b, g, r, input logic last);
        t_median_result res;
        int unsigned    rank;
        if (pixels_counted < rcm_pkg::MaxPixels) begin
            bin_count[ChBlue][b]++;
            bin_count[ChGreen][g]++;
            bin_count[ChRed][r]++;
            pixels_counted++;
        end else begin
            pixels_dropped = 1;
        end
        if (last) begin
            rank         = pixels_counted / 2;
            res.blue     = rank_value(ChBlue, rank);
            res.green    = rank_value(ChGreen, rank);
            res.red      = rank_value(ChRed, rank);
            res.total    = pixels_counted[rcm_pkg::TotalW-1:0];
            res.overflow = pixels_dropped;
            expected_medians.push_back(res);
            clear_image();
        end
    endtask

    task automatic check_field(input string name, input logic [rcm_pkg::TotalW-1:0] exp_v,
                               input logic [rcm_pkg::TotalW-1:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_v, act_v);
            o_fail_count++;
        end
    endtask

    // Compare a result request with the oldest expectation
    task automatic check_result();
        t_median_result want;
        if (expected_medians.size() == 0) begin
            $display("%0t: unexpected result: expected none, actual b=%0d g=%0d r=%0d",
                     $time, i_median_blue, i_median_green, i_median_red,
                     " n=%0d ovf=%0d", i_pixel_total, i_overflow);
            o_fail_count++;
        end else begin
            want = expected_medians.pop_front();
            check_field("median_blue", rcm_pkg::TotalW'(want.blue),
                        rcm_pkg::TotalW'(i_median_blue));
            check_field("median_green", rcm_pkg::TotalW'(want.green),
                        rcm_pkg::TotalW'(i_median_green));
            check_field("median_red", rcm_pkg::TotalW'(want.red),
                        rcm_pkg::TotalW'(i_median_red));
            check_field("pixel_total", want.total, i_pixel_total);
            check_field("overflow", rcm_pkg::TotalW'(want.overflow),
                        rcm_pkg::TotalW'(i_overflow));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_image();
            expected_medians.delete();
        end else begin
            if (i_valid && i_o_ready)
                count_pixel(i_blue, i_green, i_red, i_last_pixel);
            if (i_o_valid && i_ready)
                check_result();
        end
        o_pending = expected_medians.size();
    end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps

module tb;

    localparam int unsigned RandomItems = 1950;
    localparam int unsigned CycleLimit  = 2_000_000;
    localparam int unsigned EndWait     = 300;

    typedef enum int {
        FILL_FULL,
        FILL_NARROW,
        FILL_EXTREME
    } t_fill;

    logic                       i_clk        = 1'b0;
    logic                       i_rst_n      = 1'b0;
    logic                       i_valid      = 1'b0;
    logic [rcm_pkg::BinW-1:0]   i_blue       = '0;
    logic [rcm_pkg::BinW-1:0]   i_green      = '0;
    logic [rcm_pkg::BinW-1:0]   i_red        = '0;
    logic                       i_last_pixel = 1'b0;
    logic                       i_ready      = 1'b0;
    logic                       o_ready;
    logic                       o_valid;
    logic [rcm_pkg::BinW-1:0]   o_median_blue;
    logic [rcm_pkg::BinW-1:0]   o_median_green;
    logic [rcm_pkg::BinW-1:0]   o_median_red;
    logic [rcm_pkg::TotalW-1:0] o_pixel_total;
    logic                       o_overflow;

    int          fail_count;
    int          pending;
    int unsigned cycle_count  = 0;
    int unsigned ready_left   = 0;
    int unsigned random_sent  = 0;

    always #4 i_clk = ~i_clk;

    rgb_channel_median dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_blue         (i_blue),
        .i_green        (i_green),
        .i_red          (i_red),
        .i_last_pixel   (i_last_pixel),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_median_blue  (o_median_blue),
        .o_median_green (o_median_green),
        .o_median_red   (o_median_red),
        .o_pixel_total  (o_pixel_total),
        .o_overflow     (o_overflow)
    );

    median_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .i_o_ready      (o_ready),
        .i_blue         (i_blue),
        .i_green        (i_green),
        .i_red          (i_red),
        .i_last_pixel   (i_last_pixel),
        .i_o_valid      (o_valid),
        .i_ready        (i_ready),
        .i_median_blue  (o_median_blue),
        .i_median_green (o_median_green),
        .i_median_red   (o_median_red),
        .i_pixel_total  (o_pixel_total),
        .i_overflow     (o_overflow),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    // Mostly short gaps, now and then a long one
    function automatic int unsigned gap_len();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 65)
            return 0;
        else if (pick < 95)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    function automatic logic [rcm_pkg::BinW-1:0] pick_value(input t_fill style,
                                                            input int unsigned base);
        case (style)
            FILL_NARROW:  return rcm_pkg::BinW'(base + $urandom_range(0, 3));
            FILL_EXTREME: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
            default:      return rcm_pkg::BinW'($urandom_range(0, 255));
        endcase
    endfunction

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Result side: ready bursts and stalls of random length
    always @(posedge i_clk) begin
        if (ready_left != 0) begin
            ready_left <= ready_left - 1;
        end else if ($urandom_range(0, 99) < 55) begin
            i_ready    <= 1'b1;
            ready_left <= $urandom_range(0, 30);
        end else begin
            i_ready    <= 1'b0;
            ready_left <= gap_len();
        end
    end

    // Present one pixel request and hold it until o_ready is seen high
    task automatic send_pixel(input logic [rcm_pkg::BinW-1:0] b, g, r, input logic last);
        i_valid      <= 1'b1;
        i_blue       <= b;
        i_green      <= g;
        i_red        <= r;
        i_last_pixel <= last;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
    endtask

    task automatic idle_for(input int unsigned n);
        if (n != 0) begin
            i_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // Sender holds off until every queued result has come back
    task automatic drain_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
    endtask

    task automatic send_image(input int unsigned n, input t_fill style, input bit idle_on);
        int unsigned base;
        int unsigned k;
        base = $urandom_range(0, 255);
        for (k = 0; k < n; k++) begin
            send_pixel(pick_value(style, base), pick_value(style, base),
                       pick_value(style, base), k == n - 1);
            if (idle_on)
                idle_for(gap_len());
        end
    endtask

    initial begin
        int unsigned size;
        int unsigned pick;
        t_fill       style;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Single-pixel images at both ends of the range
        send_pixel(8'h00, 8'h00, 8'h00, 1'b1);
        send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1);
        // Even count: upper median is taken
        send_pixel(8'd10, 8'd200, 8'd0, 1'b0);
        send_pixel(8'd200, 8'd10, 8'd255, 1'b1);
        // Odd count, values rotated across channels
        send_pixel(8'd1, 8'd9, 8'd5, 1'b0);
        send_pixel(8'd5, 8'd1, 8'd9, 1'b0);
        send_pixel(8'd9, 8'd5, 8'd1, 1'b1);
        // Duplicates around the rank
        send_pixel(8'd3, 8'd3, 8'd3, 1'b0);
        send_pixel(8'd3, 8'd3, 8'd200, 1'b0);
        send_pixel(8'd8, 8'd3, 8'd200, 1'b0);
        send_pixel(8'd8, 8'd250, 8'd0, 1'b1);
        // Alternating bit patterns
        send_pixel(8'hAA, 8'h55, 8'hAA, 1'b0);
        send_pixel(8'h55, 8'hAA, 8'h55, 1'b1);
        drain_results();

        // Random images of mixed size and value spread
        while (random_sent < RandomItems) begin
            pick = $urandom_range(0, 99);
            if (pick < 75)
                size = $urandom_range(1, 12);
            else if (pick < 97)
                size = $urandom_range(13, 64);
            else
                size = $urandom_range(65, 300);
            pick = $urandom_range(0, 9);
            style = (pick < 5) ? FILL_FULL : (pick < 8) ? FILL_NARROW : FILL_EXTREME;
            send_image(size, style, $urandom_range(0, 3) != 0);
            random_sent += size;
            if ($urandom_range(0, 19) == 0)
                drain_results();
        end

        // Wind down
        drain_results();
        repeat (EndWait) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
